@@ sv/literal_escape_decoder_defines.svh @@
// Assertion macros for the decoder's output queue module.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef LITERAL_ESCAPE_DECODER_DEFINES_SVH
`define LITERAL_ESCAPE_DECODER_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define LED_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// The antecedent implies the consequent in the same cycle.
`define LED_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/led_pkg.sv @@
package led_pkg;

  // Output queue depth in entries, each holding one input byte's results.
  localparam int unsigned OUT_DEPTH = 2;

  localparam int unsigned VALUE_W = 18;
  localparam int unsigned CNT_W   = 3;

  // Character codes.
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_F   = 8'h66;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CTL_FF    = 8'h0C;
  localparam logic [7:0] CTL_CR    = 8'h0D;
  localparam logic [7:0] CTL_TAB   = 8'h09;

  // Digit limits of the numeric escapes.
  localparam logic [CNT_W-1:0] OCT_LIMIT = 3'd6;
  localparam logic [CNT_W-1:0] DEC_LIMIT = 3'd5;
  localparam logic [CNT_W-1:0] HEX_LIMIT = 3'd4;

  // Reset value of the quote character register.
  localparam logic [7:0] QUOTE_RESET = 8'h22;

  // Configuration register indexes.
  localparam logic CFG_ESCAPES_ENABLED = 1'b0;
  localparam logic CFG_QUOTE_CHAR      = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_ESC  = 3'd1,
    MODE_OCT  = 3'd2,
    MODE_DEC  = 3'd3,
    MODE_HEX  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    RT_CHAR  = 2'd0,
    RT_END   = 2'd1,
    RT_ERROR = 2'd2
  } rtype_e;

  typedef struct packed {
    logic       escapes_enabled;
    logic [7:0] quote_char;
  } cfg_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    rtype_e             rtype;
    logic               last;
  } result_t;

  // All results caused by one input byte; r1 is used only when two is set.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } item_t;

  // Outcome of a byte handled outside an escape.
  typedef struct packed {
    logic    emit;
    logic    to_esc;
    result_t res;
  } idle_t;

  function automatic idle_t idle_byte(logic [7:0] ch, cfg_t cfg);
    idle_t r;
    r.emit      = 1'b1;
    r.to_esc    = 1'b0;
    r.res.last  = 1'b0;
    r.res.value = '0;
    r.res.rtype = RT_CHAR;
    if (ch == cfg.quote_char) begin
      r.res.rtype = RT_END;
    end else if (ch == CH_LF) begin
      r.res.rtype = RT_ERROR;
    end else if (ch == CH_BSLASH && cfg.escapes_enabled) begin
      r.emit   = 1'b0;
      r.to_esc = 1'b1;
    end else begin
      r.res.value = VALUE_W'(ch);
    end
    return r;
  endfunction

  // Maps the byte after a lone backslash to its character.
  function automatic logic [7:0] escape_char(logic [7:0] ch);
    logic [7:0] v;
    v = ch;
    if (ch == CH_LB)        v = CTL_BS;
    else if (ch == CH_LF_F) v = CTL_FF;
    else if (ch == CH_LN)   v = CH_LF;
    else if (ch == CH_LR)   v = CTL_CR;
    else if (ch == CH_LT)   v = CTL_TAB;
    return v;
  endfunction

endpackage

@@ sv/literal_escape_decoder.sv @@
// Path: an accepted byte is held in the input register, decoded
// combinationally and written into the result queue, which drives the output.
// Throughput: one byte per cycle while the result queue has room; a byte that
// gives two results is one queue entry that leaves as two output words.
// Reset: rst_ni is asynchronous and active low; it clears the escape state,
// the queue and the input valid flag, and sets escapes on and the quote to '"'.
module literal_escape_decoder #(
  parameter int unsigned OutDepth = led_pkg::OUT_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [17:0] value, [23:18] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] result_type
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic             in_valid_q;
  logic [7:0]       in_ch_q;
  logic             accept, fire, q_ready;
  logic [1:0]       nres;
  led_pkg::item_t   item;
  led_pkg::result_t res;
  led_pkg::cfg_t    cfg_q;

  // Input register: refills in the same cycle its byte is consumed.
  assign fire          = in_valid_q && q_ready;
  assign s_axis_tready = !in_valid_q || fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_ch_q <= s_axis_tdata;
    end
  end

  // Configuration registers, always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.escapes_enabled <= 1'b1;
      cfg_q.quote_char      <= led_pkg::QUOTE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        led_pkg::CFG_ESCAPES_ENABLED: cfg_q.escapes_enabled <= cfg_data_i[0];
        led_pkg::CFG_QUOTE_CHAR:      cfg_q.quote_char      <= cfg_data_i;
      endcase
    end
  end

  led_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .ch_i   (in_ch_q),
    .cfg_i  (cfg_q),
    .nres_o (nres),
    .item_o (item)
  );

  led_out_queue #(
    .Depth (OutDepth)
  ) u_out_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (fire && (nres != 2'd0)),
    .item_i    (item),
    .ready_o   (q_ready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_o     (res)
  );

  assign m_axis_tdata = {6'd0, res.value};
  assign m_axis_tuser = res.rtype;
  assign m_axis_tlast = res.last;

endmodule

@@ sv/led_decode.sv @@
module led_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    ch_i,
  input  led_pkg::cfg_t cfg_i,
  output logic [1:0]    nres_o,
  output led_pkg::item_t item_o
);

  localparam int unsigned VW = led_pkg::VALUE_W;

  led_pkg::mode_e           mode_q, mode_d;
  logic [VW-1:0]            acc_q, acc_d;
  logic [led_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_inc, limit;
  logic                     dig_ok;
  logic [3:0]               dig;
  logic [VW-1:0]            acc_mul, acc_new;
  led_pkg::idle_t           idl;
  led_pkg::result_t         r0, r1;
  logic [1:0]               nres;

  // Digit recognition for the current numeric mode.
  always_comb begin
    dig_ok = 1'b0;
    dig    = 4'd0;
    limit  = led_pkg::HEX_LIMIT;
    unique case (mode_q)
      led_pkg::MODE_OCT: begin
        limit  = led_pkg::OCT_LIMIT;
        dig_ok = (ch_i >= led_pkg::CH_0) && (ch_i <= led_pkg::CH_7);
        dig    = 4'(ch_i - led_pkg::CH_0);
      end
      led_pkg::MODE_DEC: begin
        limit  = led_pkg::DEC_LIMIT;
        dig_ok = (ch_i >= led_pkg::CH_0) && (ch_i <= led_pkg::CH_9);
        dig    = 4'(ch_i - led_pkg::CH_0);
      end
      default: begin
        if ((ch_i >= led_pkg::CH_0) && (ch_i <= led_pkg::CH_9)) begin
          dig_ok = 1'b1;
          dig    = 4'(ch_i - led_pkg::CH_0);
        end else if ((ch_i >= led_pkg::CH_UA) && (ch_i <= led_pkg::CH_UF)) begin
          dig_ok = 1'b1;
          dig    = 4'(ch_i - led_pkg::CH_UA + 8'd10);
        end else if ((ch_i >= led_pkg::CH_LA) && (ch_i <= led_pkg::CH_LF_F)) begin
          dig_ok = 1'b1;
          dig    = 4'(ch_i - led_pkg::CH_LA + 8'd10);
        end
      end
    endcase
  end

  // Radix scaling uses shifts and no multiplier; times ten is eight plus two.
  always_comb begin
    unique case (mode_q)
      led_pkg::MODE_OCT: acc_mul = {acc_q[VW-4:0], 3'b000};
      led_pkg::MODE_DEC: acc_mul = {acc_q[VW-4:0], 3'b000} + {acc_q[VW-2:0], 1'b0};
      default:           acc_mul = {acc_q[VW-5:0], 4'b0000};
    endcase
    acc_new = acc_mul + VW'(dig);
    cnt_inc = cnt_q + 3'd1;
  end

  assign idl = led_pkg::idle_byte(ch_i, cfg_i);

  // Next state and results for the byte in the input register.
  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    nres     = 2'd0;
    r0       = '0;
    r1       = '0;
    r0.rtype = led_pkg::RT_CHAR;
    r1.rtype = led_pkg::RT_CHAR;
    unique case (mode_q)
      led_pkg::MODE_ESC: begin
        mode_d = led_pkg::MODE_IDLE;
        if (ch_i == led_pkg::CH_0) begin
          mode_d = led_pkg::MODE_OCT;
          acc_d  = '0;
          cnt_d  = 3'd1;
        end else if ((ch_i >= led_pkg::CH_1) && (ch_i <= led_pkg::CH_9)) begin
          mode_d = led_pkg::MODE_DEC;
          acc_d  = VW'(ch_i - led_pkg::CH_0);
          cnt_d  = 3'd1;
        end else if (ch_i == led_pkg::CH_LX || ch_i == led_pkg::CH_UX) begin
          mode_d = led_pkg::MODE_HEX;
          acc_d  = '0;
          cnt_d  = 3'd0;
        end else if (ch_i != led_pkg::CH_LF) begin
          // A backslash-newline is a continuation and gives nothing.
          nres     = 2'd1;
          r0.value = VW'(led_pkg::escape_char(ch_i));
        end
      end
      led_pkg::MODE_OCT, led_pkg::MODE_DEC, led_pkg::MODE_HEX: begin
        if (dig_ok) begin
          acc_d = acc_new;
          cnt_d = cnt_inc;
          if (cnt_inc >= limit) begin
            nres     = 2'd1;
            r0.value = acc_new;
            mode_d   = led_pkg::MODE_IDLE;
          end
        end else begin
          // The number ends, then the byte is handled on its own.
          r0.value = acc_q;
          mode_d   = idl.to_esc ? led_pkg::MODE_ESC : led_pkg::MODE_IDLE;
          if (idl.emit) begin
            nres = 2'd2;
            r1   = idl.res;
          end else begin
            nres = 2'd1;
          end
        end
      end
      default: begin
        mode_d = idl.to_esc ? led_pkg::MODE_ESC : led_pkg::MODE_IDLE;
        if (idl.emit) begin
          nres = 2'd1;
          r0   = idl.res;
        end
      end
    endcase
    r0.last = (nres == 2'd1);
    r1.last = 1'b1;
  end

  assign nres_o      = nres;
  assign item_o.two  = (nres == 2'd2);
  assign item_o.r0   = r0;
  assign item_o.r1   = r1;

  // Escape state advances only when the byte is consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= led_pkg::MODE_IDLE;
      acc_q  <= '0;
      cnt_q  <= '0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

@@ sv/led_out_queue.sv @@
`include "literal_escape_decoder_defines.svh"

module led_out_queue #(
  parameter int unsigned Depth = led_pkg::OUT_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  led_pkg::item_t   item_i,
  output logic             ready_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output led_pkg::result_t res_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  led_pkg::item_t  mem_q [Depth];
  led_pkg::item_t  head;
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic            sel_q, sel_d;
  logic            pop, take;

  assign head      = mem_q[rd_ptr_q];
  assign ready_o   = (count_q != Full);
  assign m_valid_o = (count_q != '0);
  assign res_o     = sel_q ? head.r1 : head.r0;

  // A word is taken per output handshake; the entry leaves on its last word.
  assign take = m_valid_o && m_ready_i;
  assign pop  = take && (sel_q || !head.two);

  always_comb begin
    sel_d = sel_q;
    if (take) begin
      sel_d = !pop;
    end
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop) begin
      count_d = count_q - 1'b1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers, fill count and result select.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      sel_q    <= 1'b0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
      sel_q   <= sel_d;
    end
  end

  `LED_ASSERT_ALWAYS(a_count_bound, count_q <= Full)
  `LED_ASSERT_IMPL(a_no_push_full, push_i, count_q != Full)
  `LED_ASSERT_IMPL(a_second_needs_two, sel_q, m_valid_o && head.two)
  `LED_ASSERT_IMPL(a_last_on_pop, take, res_o.last == pop)

endmodule
